// ===== design/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg: shared types, codes and helpers for the PID distance controller
// Controller states, datapath command/status bundles, register indexes and
// the fixed-point rounding and saturation helpers.
// ----------------------------------------------------------------------------
package pdc_pkg;

   // Item kinds carried on req_tuser
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_TARGET     = 3'd0;
   localparam logic [2:0] CSR_INT_LIMIT  = 3'd1;
   localparam logic [2:0] CSR_TOLERANCE  = 3'd2;
   localparam logic [2:0] CSR_GAIN_P     = 3'd3;
   localparam logic [2:0] CSR_GAIN_I     = 3'd4;
   localparam logic [2:0] CSR_GAIN_D     = 3'd5;
   localparam logic [2:0] CSR_IN_PER_DEG = 3'd6;
   localparam logic [2:0] CSR_PERIOD     = 3'd7;

   // Register reset values
   localparam logic [23:0] GAIN_P_RST     = 24'd458752;
   localparam logic [23:0] GAIN_I_RST     = 24'd32768;
   localparam logic [23:0] GAIN_D_RST     = 24'd218453;
   localparam logic [23:0] IN_PER_DEG_RST = 24'd285503;
   localparam logic [15:0] PERIOD_RST     = 16'd983;

   // Datapath widths
   localparam int PROD_W = 58;   // 33b signed x 25b signed
   localparam int ACC_W  = 60;   // sum of three products
   localparam int RND_W  = 44;   // accumulator after dropping 16 fraction bits

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST_MUL,
      ST_DIST,
      ST_ERR,
      ST_INT_MUL,
      ST_INT,
      ST_I_MUL,
      ST_D_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OUT_START,
      OUT_IDLE,
      OUT_RUN
   } out_mode_type;

   typedef enum logic [2:0] {
      MUL_ANGLE_IPD,
      MUL_ERR_SP,
      MUL_ERR_GP,
      MUL_INTEG_GI,
      MUL_DERIV_GD
   } mul_sel_type;

   typedef struct packed {
      logic         in_ld;
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         dist_ld;
      logic         err_ld;
      logic         deriv_ld;
      logic         integ_ld;
      logic         acc_ld;
      logic         acc_add;
      logic         out_ld;
      out_mode_type out_mode;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

   // Round to nearest, ties toward +infinity, drop 16 fraction bits
   function automatic logic signed [RND_W-1:0] round16(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      t = x + ACC_W'(32768);
      return t[ACC_W-1:16];
   endfunction

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] x);
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] lo;
      hi = RND_W'(64'sd2147483647);
      lo = -RND_W'(64'sd2147483648);
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

// ===== design/pdc_datapath.sv =====
// ----------------------------------------------------------------------------
// pdc_datapath: registers and arithmetic of the PID distance controller
// Holds the configuration registers, loop state, one shared multiplier with
// its product register, the accumulator and the result register.
// ----------------------------------------------------------------------------
module pdc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  logic [31:0]          req_tdata,
   input  pdc_pkg::cmd_type     cmd,
   output pdc_pkg::status_type  status,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tuser
);

   // configuration
   logic signed [31:0] target_ff;
   logic [30:0]        limit_ff;
   logic [30:0]        tol_ff;
   logic [23:0]        gain_p_ff;
   logic [23:0]        gain_i_ff;
   logic [23:0]        gain_d_ff;
   logic [23:0]        ipd_ff;
   logic [15:0]        period_ff;

   // loop state
   logic signed [31:0] integ_ff;
   logic signed [31:0] integ_in;
   logic signed [31:0] prev_ff;

   // working registers
   logic signed [31:0]                 angle_ff;
   logic signed [31:0]                 dist_ff;
   logic signed [31:0]                 dist_in;
   logic signed [31:0]                 err_ff;
   logic signed [31:0]                 err_in;
   logic signed [32:0]                 deriv_ff;
   logic signed [32:0]                 deriv_in;
   logic signed [pdc_pkg::PROD_W-1:0]  prod_ff;
   logic signed [pdc_pkg::ACC_W-1:0]   acc_ff;
   logic signed [pdc_pkg::ACC_W-1:0]   acc_in;
   logic signed [31:0]                 drive_ff;
   logic signed [31:0]                 drive_in;
   logic                               done_ff;
   logic                               done_w;

   // shared multiplier
   logic signed [32:0]                 mul_a;
   logic [23:0]                        mul_b;
   logic signed [pdc_pkg::PROD_W-1:0]  mul_p;

   logic signed [pdc_pkg::ACC_W-1:0]   prod_ext;
   logic signed [pdc_pkg::RND_W-1:0]   prod_rnd;
   logic signed [pdc_pkg::RND_W-1:0]   err_wide;
   logic signed [pdc_pkg::RND_W-1:0]   integ_wide;
   logic signed [pdc_pkg::RND_W-1:0]   lim_wide;
   logic [32:0]                        err_mag;
   logic [32:0]                        target_mag;

   always_comb begin
      unique case (cmd.mul_sel)
         pdc_pkg::MUL_ANGLE_IPD: begin
            mul_a = {angle_ff[31], angle_ff};
            mul_b = ipd_ff;
         end
         pdc_pkg::MUL_ERR_SP: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {8'd0, period_ff};
         end
         pdc_pkg::MUL_ERR_GP: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = gain_p_ff;
         end
         pdc_pkg::MUL_INTEG_GI: begin
            mul_a = {integ_ff[31], integ_ff};
            mul_b = gain_i_ff;
         end
         pdc_pkg::MUL_DERIV_GD: begin
            mul_a = deriv_ff;
            mul_b = gain_d_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * $signed({1'b0, mul_b});

   assign prod_ext = {{(pdc_pkg::ACC_W - pdc_pkg::PROD_W){prod_ff[pdc_pkg::PROD_W-1]}}, prod_ff};
   assign prod_rnd = pdc_pkg::round16(prod_ext);

   // distance and error, both saturated
   assign dist_in  = pdc_pkg::sat32(prod_rnd);
   assign err_wide = {{(pdc_pkg::RND_W-32){target_ff[31]}}, target_ff}
                   - {{(pdc_pkg::RND_W-32){dist_ff[31]}}, dist_ff};
   assign err_in   = pdc_pkg::sat32(err_wide);
   assign deriv_in = {err_ff[31], err_ff} - {prev_ff[31], prev_ff};

   // integral with symmetric clamp
   assign lim_wide   = {{(pdc_pkg::RND_W-31){1'b0}}, limit_ff};
   assign integ_wide = prod_rnd + {{(pdc_pkg::RND_W-32){integ_ff[31]}}, integ_ff};

   always_comb begin
      priority if (integ_wide > lim_wide) begin
         integ_in = lim_wide[31:0];
      end else if (integ_wide < -lim_wide) begin
         integ_in = 32'(-lim_wide);
      end else begin
         integ_in = integ_wide[31:0];
      end
   end

   always_comb begin
      priority if (cmd.acc_ld) begin
         acc_in = prod_ext;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + prod_ext;
      end else begin
         acc_in = acc_ff;
      end
   end

   // done test and result
   assign err_mag    = err_ff[31] ? 33'(-{err_ff[31], err_ff}) : {1'b0, err_ff};
   assign target_mag = target_ff[31] ? 33'(-{target_ff[31], target_ff}) : {1'b0, target_ff};

   always_comb begin
      unique case (cmd.out_mode)
         pdc_pkg::OUT_START: begin
            done_w   = target_mag <= {2'b00, tol_ff};
            drive_in = '0;
         end
         pdc_pkg::OUT_RUN: begin
            done_w   = err_mag <= {2'b00, tol_ff};
            drive_in = pdc_pkg::sat32(pdc_pkg::round16(acc_ff));
         end
         default: begin
            done_w   = 1'b1;
            drive_in = '0;
         end
      endcase
   end

   assign status.done = done_w;

   // configuration and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         limit_ff  <= '0;
         tol_ff    <= '0;
         gain_p_ff <= pdc_pkg::GAIN_P_RST;
         gain_i_ff <= pdc_pkg::GAIN_I_RST;
         gain_d_ff <= pdc_pkg::GAIN_D_RST;
         ipd_ff    <= pdc_pkg::IN_PER_DEG_RST;
         period_ff <= pdc_pkg::PERIOD_RST;
         integ_ff  <= '0;
         prev_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               pdc_pkg::CSR_TARGET:     target_ff <= csr_wdata;
               pdc_pkg::CSR_INT_LIMIT:  limit_ff  <= csr_wdata[30:0];
               pdc_pkg::CSR_TOLERANCE:  tol_ff    <= csr_wdata[30:0];
               pdc_pkg::CSR_GAIN_P:     gain_p_ff <= csr_wdata[23:0];
               pdc_pkg::CSR_GAIN_I:     gain_i_ff <= csr_wdata[23:0];
               pdc_pkg::CSR_GAIN_D:     gain_d_ff <= csr_wdata[23:0];
               pdc_pkg::CSR_IN_PER_DEG: ipd_ff    <= csr_wdata[23:0];
               pdc_pkg::CSR_PERIOD:     period_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.integ_ld) begin
            integ_ff <= integ_in;
            prev_ff  <= err_ff;
         end else if (cmd.out_ld && cmd.out_mode == pdc_pkg::OUT_START) begin
            integ_ff <= '0;
            prev_ff  <= target_ff;
         end
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      if (cmd.in_ld) begin
         angle_ff <= req_tdata;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.dist_ld) begin
         dist_ff <= dist_in;
      end
      if (cmd.err_ld) begin
         err_ff <= err_in;
      end
      if (cmd.deriv_ld) begin
         deriv_ff <= deriv_in;
      end
      acc_ff <= acc_in;
      if (cmd.out_ld) begin
         drive_ff <= drive_in;
         done_ff  <= done_w;
      end
   end

   assign rsp_tdata = drive_ff;
   assign rsp_tuser = done_ff;

endmodule

// ===== design/pdc_controller.sv =====
// ----------------------------------------------------------------------------
// pdc_controller: sequencer of the PID distance controller
// Accepts one beat at a time, steps the datapath through the shared
// multiplier schedule, tracks the running flag and owns the result valid.
// ----------------------------------------------------------------------------
module pdc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output pdc_pkg::cmd_type     cmd,
   input  pdc_pkg::status_type  status
);

   pdc_pkg::state_type    state_ff;
   pdc_pkg::state_type    state_in;
   pdc_pkg::out_mode_type mode_ff;
   pdc_pkg::out_mode_type mode_in;
   logic                  running_ff;
   logic                  running_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic                  accept;
   logic                  out_fire;

   assign req_tready = state_ff == pdc_pkg::ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign out_fire   = state_ff == pdc_pkg::ST_OUT && !(valid_ff && !rsp_tready);

   // pick the path for the new beat
   always_comb begin
      priority if (req_tuser == pdc_pkg::CMD_START) begin
         mode_in = pdc_pkg::OUT_START;
      end else if (running_ff) begin
         mode_in = pdc_pkg::OUT_RUN;
      end else begin
         mode_in = pdc_pkg::OUT_IDLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pdc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (mode_in == pdc_pkg::OUT_RUN) ? pdc_pkg::ST_DIST_MUL
                                                        : pdc_pkg::ST_OUT;
            end
         end
         pdc_pkg::ST_DIST_MUL: state_in = pdc_pkg::ST_DIST;
         pdc_pkg::ST_DIST:     state_in = pdc_pkg::ST_ERR;
         pdc_pkg::ST_ERR:      state_in = pdc_pkg::ST_INT_MUL;
         pdc_pkg::ST_INT_MUL:  state_in = pdc_pkg::ST_INT;
         pdc_pkg::ST_INT:      state_in = pdc_pkg::ST_I_MUL;
         pdc_pkg::ST_I_MUL:    state_in = pdc_pkg::ST_D_MUL;
         pdc_pkg::ST_D_MUL:    state_in = pdc_pkg::ST_SUM;
         pdc_pkg::ST_SUM:      state_in = pdc_pkg::ST_OUT;
         pdc_pkg::ST_OUT: begin
            if (out_fire) begin
               state_in = pdc_pkg::ST_IDLE;
            end
         end
         default: state_in = pdc_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = pdc_pkg::MUL_ANGLE_IPD;
      cmd.out_mode = mode_ff;
      unique case (state_ff)
         pdc_pkg::ST_IDLE: begin
            cmd.in_ld = accept;
         end
         pdc_pkg::ST_DIST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pdc_pkg::MUL_ANGLE_IPD;
         end
         pdc_pkg::ST_DIST: begin
            cmd.dist_ld = 1'b1;
         end
         pdc_pkg::ST_ERR: begin
            cmd.err_ld = 1'b1;
         end
         pdc_pkg::ST_INT_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = pdc_pkg::MUL_ERR_SP;
            cmd.deriv_ld = 1'b1;
         end
         pdc_pkg::ST_INT: begin
            cmd.integ_ld = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = pdc_pkg::MUL_ERR_GP;
         end
         pdc_pkg::ST_I_MUL: begin
            cmd.acc_ld  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pdc_pkg::MUL_INTEG_GI;
         end
         pdc_pkg::ST_D_MUL: begin
            cmd.acc_add = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pdc_pkg::MUL_DERIV_GD;
         end
         pdc_pkg::ST_SUM: begin
            cmd.acc_add = 1'b1;
         end
         pdc_pkg::ST_OUT: begin
            cmd.out_ld = out_fire;
         end
         default: ;
      endcase
   end

   // running flag and result valid
   always_comb begin
      running_in = running_ff;
      if (out_fire) begin
         unique case (mode_ff)
            pdc_pkg::OUT_START: running_in = !status.done;
            pdc_pkg::OUT_RUN:   running_in = running_ff && !status.done;
            default:            running_in = running_ff;
         endcase
      end
      if (out_fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pdc_pkg::ST_IDLE;
         mode_ff    <= pdc_pkg::OUT_IDLE;
         running_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         running_ff <= running_in;
         valid_ff   <= valid_in;
         if (accept) begin
            mode_ff <= mode_in;
         end
      end
   end

   assign rsp_tvalid = valid_ff;

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("beat accepted while previous beat still in work");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register loaded over an unconsumed result");

   a_run_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(running_ff) |-> $past(cmd.out_ld && cmd.out_mode == pdc_pkg::OUT_START))
      else $error("running set by something other than a start beat");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld && status.done |=> !running_ff)
      else $error("running still set after a done result");
`endif

endmodule

// ===== design/pid_distance_controller_core.sv =====
// ----------------------------------------------------------------------------
// pid_distance_controller_core: fixed-point PID loop for a distance move
// Top level: joins the sequencer and the datapath and exposes the request,
// response and register-write ports.
// ----------------------------------------------------------------------------
// One beat is in work at a time. A start beat, or a sample beat that arrives
// while no move runs, is accepted and then loaded into the result register.
// A sample beat during a move uses the shared 33x25-bit multiplier five
// times in sequence (angle to distance, error times period, then the three
// gain products), and each product is registered before it is rounded or
// accumulated. req_tready rises again in the cycle after the result is
// loaded; a result that waits on rsp_tready holds the final load, and with
// it the acceptance of the next beat.
// All values are Q16.16 with round-to-nearest (ties up) and saturation to
// 32 bits; the integral is clamped to +/- integral_limit. Write registers
// only while no beat is in work.
// ----------------------------------------------------------------------------
module pid_distance_controller_core (
   input  logic        clock,
   input  logic        reset,
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] rotation_angle
   input  logic        req_tuser,   // [0] cmd: 0 start a move, 1 sensor sample
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] drive
   output logic        rsp_tuser    // [0] done_res
);

   // command and status bundles between sequencer and datapath
   pdc_pkg::cmd_type    cmd;
   pdc_pkg::status_type status;

   // sequence each beat, own handshakes and the running flag
   pdc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // hold registers and loop state, do the arithmetic
   pdc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== tb/sv/pid_distance_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// pid_distance_controller_core_tb: self-checking bench for the PID distance core
// Drives start and sample beats with random gaps, applies register settings
// between phases, predicts every drive/done result in a cycle-free software
// PID loop and checks each response beat against it in order.
// ----------------------------------------------------------------------------
module pid_distance_controller_core_tb;

   typedef struct packed {
      logic        cmd;
      logic [31:0] angle;
   } move_beat_type;

   typedef struct packed {
      logic [31:0] drive;
      logic        done;
   } drive_result_type;

   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = pdc_pkg::CSR_TARGET;
   logic [31:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] rotation_angle
   logic        req_tuser  = pdc_pkg::CMD_START;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] drive
   logic        rsp_tuser;         // [0] done_res

   // Beats waiting for the driver, and drive results still owed by the core
   move_beat_type    pending_beats[$];
   drive_result_type expected_drive[$];

   // Shadow copy of the register file, as the core sees it after each write
   longint tgt_q    = 0;
   longint lim_q    = 0;
   longint tol_q    = 0;
   longint gain_p_q = longint'(pdc_pkg::GAIN_P_RST);
   longint gain_i_q = longint'(pdc_pkg::GAIN_I_RST);
   longint gain_d_q = longint'(pdc_pkg::GAIN_D_RST);
   longint ipd_q    = longint'(pdc_pkg::IN_PER_DEG_RST);
   longint period_q = longint'(pdc_pkg::PERIOD_RST);

   // Shadow loop state
   longint integ_acc   = 0;
   longint prev_err    = 0;
   bit     move_active = 1'b0;

   int mismatch_count = 0;
   bit req_fire       = 1'b0;
   bit no_idle        = 1'b0;
   bit hold_off_req   = 1'b0;
   bit hold_off_taken = 1'b0;
   int send_gap       = 0;
   int recv_gap       = 0;
   int hold_left      = 0;

   pid_distance_controller_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Drop 16 fraction bits, rounding to nearest with ties going up.
   // Arithmetic shift on a signed longint is a floor, which is what we want.
   function automatic longint round_q16(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clamp_s32(input longint x);
      if (x > S32_HI) begin
         return S32_HI;
      end
      if (x < S32_LO) begin
         return S32_LO;
      end
      return x;
   endfunction

   // Advance the shadow loop by one beat and return the result it owes.
   function automatic drive_result_type compute_drive(input logic cmd, input logic [31:0] angle);
      drive_result_type r;
      longint           dist_val;
      longint           err;
      longint           integ;
      longint           deriv;
      longint           total;
      r.drive = '0;
      if (cmd == pdc_pkg::CMD_START) begin
         // New move: clear the integral, seed the derivative with the target
         integ_acc   = 0;
         prev_err    = tgt_q;
         r.done      = ((tgt_q < 0 ? -tgt_q : tgt_q) <= tol_q);
         move_active = !r.done;
      end else if (!move_active) begin
         // Sample with no move in progress: brake, state untouched
         r.done = 1'b1;
      end else begin
         dist_val = clamp_s32(round_q16(longint'($signed(angle)) * ipd_q));
         err      = clamp_s32(tgt_q - dist_val);
         integ    = integ_acc + round_q16(err * period_q);
         // Clamp on both sides after every add
         if (integ > lim_q) begin
            integ = lim_q;
         end
         if (integ < -lim_q) begin
            integ = -lim_q;
         end
         integ_acc = integ;
         deriv     = err - prev_err;
         prev_err  = err;
         total     = gain_p_q * err + gain_i_q * integ + gain_d_q * deriv;
         r.drive   = 32'(clamp_s32(round_q16(total)));
         // Reaching tolerance still emits the computed drive, then ends the move
         r.done    = ((err < 0 ? -err : err) <= tol_q);
         if (r.done) begin
            move_active = 1'b0;
         end
      end
      return r;
   endfunction

   // Mostly back-to-back, sometimes a few cycles, rarely a long pause
   function automatic int idle_cycles();
      int r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(25, 60);
   endfunction

   // Register value: mostly a usable setting, now and then an extreme or raw noise
   function automatic logic [31:0] pick_value(input logic [31:0] ext_lo,
                                              input logic [31:0] ext_hi,
                                              input logic [31:0] usual);
      case ($urandom_range(0, 9))
         0: begin
            return ext_lo;
         end
         1: begin
            return ext_hi;
         end
         2: begin
            return $urandom;
         end
         default: begin
            return usual;
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic push_beat(input logic cmd, input logic [31:0] angle);
      pending_beats.push_back('{cmd: cmd, angle: angle});
   endtask

   // Write one register at the falling edge and mirror it into the shadow copy.
   // Only call while no beat is in work.
   task automatic write_csr(input logic [2:0] reg_index, input logic [31:0] reg_value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= reg_value;
      case (reg_index)
         pdc_pkg::CSR_TARGET: begin
            tgt_q = longint'($signed(reg_value));
         end
         pdc_pkg::CSR_INT_LIMIT: begin
            lim_q = longint'(reg_value[30:0]);
         end
         pdc_pkg::CSR_TOLERANCE: begin
            tol_q = longint'(reg_value[30:0]);
         end
         pdc_pkg::CSR_GAIN_P: begin
            gain_p_q = longint'(reg_value[23:0]);
         end
         pdc_pkg::CSR_GAIN_I: begin
            gain_i_q = longint'(reg_value[23:0]);
         end
         pdc_pkg::CSR_GAIN_D: begin
            gain_d_q = longint'(reg_value[23:0]);
         end
         pdc_pkg::CSR_IN_PER_DEG: begin
            ipd_q = longint'(reg_value[23:0]);
         end
         pdc_pkg::CSR_PERIOD: begin
            period_q = longint'(reg_value[15:0]);
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued beat is taken and every result is back, then let
   // a full sample pass worth of cycles go by so the core is truly quiet.
   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_tvalid || expected_drive.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: change at the falling edge, hold a beat until it is taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      move_beat_type next_beat;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_fire) begin
         // Previous beat is gone (or none was up): idle out the gap, then offer
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (pending_beats.size() != 0) begin
            next_beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_beat.angle;
            req_tuser  <= next_beat.cmd;
            send_gap   <= idle_cycles();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response receiver: random stalls, plus one long hold-off on request so
   // the core backs up and drops req_tready while beats keep being offered
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
         hold_left  <= 0;
      end else if (hold_off_req && !hold_off_taken) begin
         hold_off_taken <= 1'b1;
         hold_left      <= 400;
         rsp_tready     <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap   <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         recv_gap   <= idle_cycles();
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: at each rising edge predict accepted request beats and check
   // accepted response beats against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : beat_monitor
      drive_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_drive.push_back(compute_drive(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drive.size() == 0) begin
               flag_mismatch($sformatf("unexpected result beat: drive %h done %b",
                                       rsp_tdata, rsp_tuser));
            end else begin
               want = expected_drive.pop_front();
               if (rsp_tdata !== want.drive) begin
                  flag_mismatch($sformatf("drive %h, predicted %h", rsp_tdata, want.drive));
               end
               if (rsp_tuser !== want.done) begin
                  flag_mismatch($sformatf("done %b, predicted %b", rsp_tuser, want.done));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus: directed corner cases, then random phases of moves and noise
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int     phase;
      int     sent;
      int     n;
      int     k;
      longint goal;
      longint pos;
      longint spread;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: samples with no move brake, a zero target is done at once
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h1234_5678);
      push_beat(pdc_pkg::CMD_START, 32'h0000_0000);
      push_beat(pdc_pkg::CMD_SAMPLE, 32'hFFFF_FFFF);
      wait_idle();

      // 100 inch move with a tight integral limit so it clamps on the upper side
      write_csr(pdc_pkg::CSR_TARGET, 32'd100 << 16);
      write_csr(pdc_pkg::CSR_INT_LIMIT, 32'd2 << 16);
      write_csr(pdc_pkg::CSR_TOLERANCE, 32'd1 << 16);
      push_beat(pdc_pkg::CMD_START, 32'h0000_0000);
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h0000_0000);
      push_beat(pdc_pkg::CMD_SAMPLE, 32'd92160);          // small positive angle
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h7FFF_FFFF);      // distance saturates high
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h8000_0000);      // distance low, error high
      push_beat(pdc_pkg::CMD_SAMPLE, 32'd1504352);        // lands on target: done
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h0000_0000);      // move over: ignored
      wait_idle();

      // Every gain at full scale, most negative target: lower clamp, drive saturates
      write_csr(pdc_pkg::CSR_TARGET, 32'h8000_0000);
      write_csr(pdc_pkg::CSR_INT_LIMIT, 32'h7FFF_FFFF);
      write_csr(pdc_pkg::CSR_TOLERANCE, 32'h0000_0000);
      write_csr(pdc_pkg::CSR_GAIN_P, 32'h00FF_FFFF);
      write_csr(pdc_pkg::CSR_GAIN_I, 32'h00FF_FFFF);
      write_csr(pdc_pkg::CSR_GAIN_D, 32'h00FF_FFFF);
      write_csr(pdc_pkg::CSR_IN_PER_DEG, 32'h00FF_FFFF);
      write_csr(pdc_pkg::CSR_PERIOD, 32'h0000_FFFF);
      push_beat(pdc_pkg::CMD_START, 32'hFFFF_FFFF);
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h7FFF_FFFF);
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h8000_0000);      // zero error, zero tolerance
      wait_idle();

      // Zero period and limit; widest tolerance covers the largest target
      write_csr(pdc_pkg::CSR_PERIOD, 32'h0000_0000);
      write_csr(pdc_pkg::CSR_INT_LIMIT, 32'h0000_0000);
      write_csr(pdc_pkg::CSR_TARGET, 32'h7FFF_FFFF);
      write_csr(pdc_pkg::CSR_TOLERANCE, 32'hFFFF_FFFF);   // top bit must be dropped
      push_beat(pdc_pkg::CMD_START, 32'h0000_0000);
      wait_idle();

      // Most negative target is just out of reach of the widest tolerance
      write_csr(pdc_pkg::CSR_TARGET, 32'h8000_0000);
      push_beat(pdc_pkg::CMD_START, 32'h0000_0000);
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h0000_0000);
      push_beat(pdc_pkg::CMD_SAMPLE, 32'h0000_0001);

      for (phase = 0; phase < 14; phase++) begin
         wait_idle();
         // New settings; a move left running carries into them on purpose
         write_csr(pdc_pkg::CSR_TARGET, pick_value(32'h8000_0000, 32'h7FFF_FFFF,
                   32'($urandom_range(0, 400 << 16)) - (32'd200 << 16)));
         write_csr(pdc_pkg::CSR_INT_LIMIT, pick_value(32'h0, 32'h7FFF_FFFF,
                   32'($urandom_range(0, 20 << 16))));
         write_csr(pdc_pkg::CSR_TOLERANCE, pick_value(32'h0, 32'h7FFF_FFFF,
                   32'($urandom_range(0, 3 << 16))));
         write_csr(pdc_pkg::CSR_GAIN_P, pick_value(32'h0, 32'h00FF_FFFF,
                   32'($urandom_range(0, 16 << 16))));
         write_csr(pdc_pkg::CSR_GAIN_I, pick_value(32'h0, 32'h00FF_FFFF,
                   32'($urandom_range(0, 4 << 16))));
         write_csr(pdc_pkg::CSR_GAIN_D, pick_value(32'h0, 32'h00FF_FFFF,
                   32'($urandom_range(0, 8 << 16))));
         write_csr(pdc_pkg::CSR_IN_PER_DEG, pick_value(32'h0, 32'h00FF_FFFF,
                   32'($urandom_range(100000, 600000))));
         write_csr(pdc_pkg::CSR_PERIOD, pick_value(32'h0, 32'h0000_FFFF,
                   32'($urandom_range(1, 4000))));

         no_idle = (phase % 5 == 4);
         if (phase == 3) begin
            hold_off_req = 1'b1;
         end

         sent = 0;
         while (sent < 105) begin
            if ($urandom_range(0, 9) == 0) begin
               // Noise: any kind, any angle
               push_beat(1'($urandom_range(0, 1)), $urandom);
               sent++;
            end else begin
               // Well-formed move: start, then angles closing in on the target
               n = $urandom_range(2, 20);
               push_beat(pdc_pkg::CMD_START, $urandom);
               if (ipd_q == 0) begin
                  goal = longint'($signed($urandom));
               end else begin
                  goal = clamp_s32((tgt_q * 65536) / ipd_q);
               end
               if ($urandom_range(0, 4) == 0) begin
                  goal = goal + goal / 4;       // overshoot past the target
               end
               for (k = 1; k <= n; k++) begin
                  spread = (((goal < 0 ? -goal : goal) >> 4) * (n - k)) / n + 32;
                  pos    = goal * k / n
                         + longint'($urandom_range(0, 32'(2 * spread))) - spread;
                  push_beat(pdc_pkg::CMD_SAMPLE, 32'(clamp_s32(pos)));
               end
               sent += n + 1;
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("pid_distance_controller_core: match");
      end else begin
         $display("pid_distance_controller_core: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #24000000;
      $display("timeout: results still outstanding");
      $display("pid_distance_controller_core: mismatch");
      $finish;
   end

endmodule

// ===== pid_distance_controller_core.f =====
design/pdc_pkg.sv
design/pdc_datapath.sv
design/pdc_controller.sv
design/pid_distance_controller_core.sv
tb/sv/pid_distance_controller_core_tb.sv
